/* design/measurement_frame_deframer_core_defines.svh */
// assertion macros for the measurement frame deframer checker
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef MEASUREMENT_FRAME_DEFRAMER_CORE_DEFINES_SVH
`define MEASUREMENT_FRAME_DEFRAMER_CORE_DEFINES_SVH

// same-cycle implication, off during reset
`define MFD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mfd assertion failed");

// next-cycle implication, off during reset
`define MFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mfd assertion failed");

// next-cycle implication that also watches reset itself
`define MFD_ASSERT_RST(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("mfd assertion failed");

`endif

/* design/mfd_pkg.sv */
// shared constants, types and crc helper for the measurement frame deframer
// no dependencies
`timescale 1ns / 1ps

package mfd_pkg;

    localparam int POS_W = 5;
    localparam int WORD_W = 32;
    localparam int NUM_WORDS = 3;

    typedef logic [POS_W-1:0] t_pos;
    typedef logic [WORD_W-1:0] t_word;
    typedef logic [1:0] t_word_sel;

    localparam t_pos FRAME_BYTES = t_pos'(18);
    localparam t_pos LAST_POS = t_pos'(17);

    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    localparam t_word_sel WORD_CO2 = 2'd0;
    localparam t_word_sel WORD_TEMP = 2'd1;
    localparam t_word_sel WORD_HUM = 2'd2;

    typedef struct packed {
        t_word co2;
        t_word temperature;
        t_word humidity;
        logic  ok;
    } t_result;

    // one byte through the msb-first crc-8
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    // third byte of every group carries the crc
    function automatic logic is_crc_pos(input t_pos pos);
        logic r;
        case (pos)
            5'd2, 5'd5, 5'd8, 5'd11, 5'd14, 5'd17: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    // six bytes (two groups) per word
    function automatic t_word_sel word_sel(input t_pos pos);
        t_word_sel s;
        if (pos < t_pos'(6)) begin
            s = WORD_CO2;
        end else if (pos < t_pos'(12)) begin
            s = WORD_TEMP;
        end else begin
            s = WORD_HUM;
        end
        return s;
    endfunction

endpackage

/* design/mfd_frame.sv */
// frame tracking: byte position, running crc, word assembly, accepted words
// depends on mfd_pkg
`timescale 1ns / 1ps

module mfd_frame (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  logic [7:0]      i_rx_byte,
    input  logic            i_frame_start,
    output logic            o_last,
    output mfd_pkg::t_result o_result
);
    import mfd_pkg::*;

    t_pos       r_pos, n_pos;
    logic [7:0] r_crc, n_crc;
    logic       r_failed, n_failed;
    t_word      r_build [NUM_WORDS];
    t_word      n_build [NUM_WORDS];
    t_word      r_accept [NUM_WORDS];
    t_word      n_accept [NUM_WORDS];

    t_pos       pos;
    logic       idle;
    logic       first;
    logic [7:0] crc_base;
    t_word_sel  sel;

    always_comb begin
        pos      = i_frame_start ? '0 : r_pos;
        idle     = pos >= FRAME_BYTES;
        first    = pos == '0;
        crc_base = first ? CRC_INIT : r_crc;
        sel      = word_sel(pos);

        n_pos    = r_pos;
        n_crc    = r_crc;
        n_failed = r_failed;
        n_build  = r_build;
        n_accept = r_accept;

        if (idle) begin
            n_pos = FRAME_BYTES;
        end else begin
            n_failed = first ? 1'b0 : r_failed;
            for (int k = 0; k < NUM_WORDS; k++) begin
                n_build[k] = first ? '0 : r_build[k];
            end
            if (!is_crc_pos(pos)) begin
                n_crc = crc8_step(crc_base, i_rx_byte);
                for (int k = 0; k < NUM_WORDS; k++) begin
                    if (sel == t_word_sel'(k)) begin
                        n_build[k] = {n_build[k][WORD_W-9:0], i_rx_byte};
                    end
                end
            end else begin
                if (crc_base != i_rx_byte) begin
                    n_failed = 1'b1;
                end
                n_crc = CRC_INIT;
            end
            if (pos == LAST_POS) begin
                if (!n_failed) begin
                    n_accept = n_build;
                end
                n_pos = FRAME_BYTES;
            end else begin
                n_pos = pos + t_pos'(1);
            end
        end
    end

    assign o_last                 = !idle && (pos == LAST_POS);
    assign o_result.co2           = n_accept[WORD_CO2];
    assign o_result.temperature   = n_accept[WORD_TEMP];
    assign o_result.humidity      = n_accept[WORD_HUM];
    assign o_result.ok            = !n_failed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_crc    <= CRC_INIT;
            r_failed <= 1'b0;
            for (int k = 0; k < NUM_WORDS; k++) begin
                r_build[k]  <= '0;
                r_accept[k] <= '0;
            end
        end else if (i_fire) begin
            r_pos    <= n_pos;
            r_crc    <= n_crc;
            r_failed <= n_failed;
            r_build  <= n_build;
            r_accept <= n_accept;
        end
    end

endmodule

/* design/mfd_out_reg.sv */
// result register holding one beat until the consumer takes it
// depends on mfd_pkg
`timescale 1ns / 1ps

module mfd_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  mfd_pkg::t_result i_result,
    input  logic             i_stall,
    output logic             o_free,
    output logic             o_valid,
    output mfd_pkg::t_result o_result
);
    import mfd_pkg::*;

    logic    r_valid;
    t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_free   = !r_valid || !i_stall;
    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

/* design/measurement_frame_deframer_core.sv */
// measurement frame deframer: takes response bytes, checks crc-8 per group,
// emits the three accepted words and an ok flag after byte 17 of a frame
// path: a last byte goes through the input register, then its result is loaded into the result register
// throughput: one byte per cycle, set by the combinational crc and frame update;
// a last byte waits only while the result register is full and stalled
// reset: synchronous active low; position 0, crc 0xff, all words zero, no result
`timescale 1ns / 1ps

module measurement_frame_deframer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input beats
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_frame_start,
    // result beats
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_co2_bits,
    output logic [31:0] o_temperature_bits,
    output logic [31:0] o_humidity_bits,
    output logic        o_frame_ok
);
    import mfd_pkg::*;

    // input register: one byte waiting to be folded into the frame state
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_start;

    logic    frame_last;
    logic    out_free;
    logic    proc_fire;
    logic    in_accept;
    t_result frame_result;
    t_result out_result;

    // a byte that ends a frame needs the result register free; all other
    // bytes go through without looking at the output side
    assign proc_fire  = r_in_valid && (!frame_last || out_free);
    assign o_in_stall = r_in_valid && !proc_fire;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (proc_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    // payload only moves on an accepted beat
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte  <= i_rx_byte;
            r_in_start <= i_frame_start;
        end
    end

    // crc check and word assembly, state advances once per processed byte
    mfd_frame u_frame (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (proc_fire),
        .i_rx_byte     (r_in_byte),
        .i_frame_start (r_in_start),
        .o_last        (frame_last),
        .o_result      (frame_result)
    );

    // result register decouples the consumer from the byte stream
    mfd_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (proc_fire && frame_last),
        .i_result (frame_result),
        .i_stall  (i_out_stall),
        .o_free   (out_free),
        .o_valid  (o_out_valid),
        .o_result (out_result)
    );

    assign o_co2_bits         = out_result.co2;
    assign o_temperature_bits = out_result.temperature;
    assign o_humidity_bits    = out_result.humidity;
    assign o_frame_ok         = out_result.ok;

endmodule

/* design/mfd_checker.sv */
// port-level checks for the measurement frame deframer, bound to the top level
// depends on measurement_frame_deframer_core_defines.svh
`timescale 1ns / 1ps
`include "measurement_frame_deframer_core_defines.svh"

module mfd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_co2_bits,
    input logic [31:0] o_temperature_bits,
    input logic [31:0] o_humidity_bits,
    input logic        o_frame_ok
);

    // whole result payload in one vector
    logic [96:0] out_payload;

    assign out_payload = {o_co2_bits, o_temperature_bits, o_humidity_bits, o_frame_ok};

    // a stalled result stays offered
    `MFD_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid)

    // a stalled result keeps its payload
    `MFD_ASSERT_NEXT(a_out_stable, o_out_valid && i_out_stall, $stable(out_payload))

    // nothing is offered right after reset
    `MFD_ASSERT_RST(a_rst_quiet, !i_rst_n, !o_out_valid)

    // a fresh result always follows a byte beat taken through the input register
    `MFD_ASSERT_NOW(a_out_cause, $rose(o_out_valid), $past(i_in_valid && !o_in_stall, 2))

endmodule

bind measurement_frame_deframer_core mfd_checker u_mfd_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in_valid),
    .o_in_stall         (o_in_stall),
    .o_out_valid        (o_out_valid),
    .i_out_stall        (i_out_stall),
    .o_co2_bits         (o_co2_bits),
    .o_temperature_bits (o_temperature_bits),
    .o_humidity_bits    (o_humidity_bits),
    .o_frame_ok         (o_frame_ok)
);

/* tb/tb_measurement_frame_deframer_core.sv */
// self-checking testbench for measurement_frame_deframer_core: byte beats in, crc-checked
// readings out, compared against an in-bench model of the frame and crc logic
// depends on mfd_pkg and the deframer core rtl
`timescale 1ns / 1ps

module tb_measurement_frame_deframer_core;
    import mfd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int BYTE_TARGET = 2000;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_REPORTS = 20;
    localparam int NUM_DIRECTED = 25;

    // one directed stimulus row; want is only used when typed is set
    typedef struct packed {
        logic [7:0] rx;
        logic       start;
        logic       typed;
        t_result    want;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_rx_byte;
    logic        i_frame_start;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_co2_bits;
    logic [31:0] o_temperature_bits;
    logic [31:0] o_humidity_bits;
    logic        o_frame_ok;

    // model of the frame tracker
    t_pos        frame_pos;
    logic [7:0]  group_crc;
    logic        frame_bad;
    logic [31:0] words_in_progress [NUM_WORDS];
    logic [31:0] words_kept [NUM_WORDS];

    // readings still owed by the block, oldest first
    t_result     pending_readings [$];

    int          err_count;
    int          bytes_used;
    int          readings_seen;
    int          failed_seen;
    int          cycle_count;
    int          hold_left;
    logic        hold_req;
    logic        quiet;

    measurement_frame_deframer_core uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_rx_byte          (i_rx_byte),
        .i_frame_start      (i_frame_start),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_co2_bits         (o_co2_bits),
        .o_temperature_bits (o_temperature_bits),
        .o_humidity_bits    (o_humidity_bits),
        .o_frame_ok         (o_frame_ok)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // crc-8, poly 0x31, msb first, fed one data bit at a time
    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] d);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[7] ^ d[i];
            c = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    // advance the frame model by one accepted byte
    // consumed is low when the byte falls into the idle gap after a frame
    task automatic track_byte(input logic [7:0] b, input logic s, output logic consumed,
                              output logic has_reading, output t_result reading);
        int pos;
        int w;
        pos = s ? 0 : int'(frame_pos);
        consumed = 1'b0;
        has_reading = 1'b0;
        reading = '0;
        if (pos >= int'(FRAME_BYTES)) begin
            // idle: ignored until the next frame start
            frame_pos = FRAME_BYTES;
            return;
        end
        consumed = 1'b1;
        if (pos == 0) begin
            group_crc = CRC_INIT;
            frame_bad = 1'b0;
            for (int i = 0; i < NUM_WORDS; i++) words_in_progress[i] = '0;
        end
        w = pos / 6;
        if (pos % 3 != 2) begin
            // data byte: into the crc and shifted in big-endian
            group_crc = crc8_next(group_crc, b);
            words_in_progress[w] = {words_in_progress[w][23:0], b};
        end else begin
            // crc byte closes the group
            if (group_crc != b) frame_bad = 1'b1;
            group_crc = CRC_INIT;
        end
        if (pos == int'(LAST_POS)) begin
            if (!frame_bad) begin
                for (int i = 0; i < NUM_WORDS; i++) words_kept[i] = words_in_progress[i];
            end
            reading.co2 = words_kept[WORD_CO2];
            reading.temperature = words_kept[WORD_TEMP];
            reading.humidity = words_kept[WORD_HUM];
            reading.ok = !frame_bad;
            has_reading = 1'b1;
            frame_pos = FRAME_BYTES;
        end else begin
            frame_pos = t_pos'(pos + 1);
        end
    endtask

    // offer one byte beat, wait for it to be taken, then update the model
    // a typed reading, when given, replaces the modeled one
    task automatic send_byte(input logic [7:0] b, input logic s, input logic typed,
                             input t_result typed_val);
        logic    consumed;
        logic    has_reading;
        t_result reading;
        while (!quiet && $urandom_range(0, 99) < 19) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte <= b;
        i_frame_start <= s;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        track_byte(b, s, consumed, has_reading, reading);
        if (consumed) bytes_used++;
        if (has_reading) begin
            pending_readings.push_back(typed ? typed_val : reading);
        end
    endtask

    // six groups of two data bytes plus crc; a set mask bit spoils that group's crc
    // fill: 0 random data, 1 all zero, 2 all ones
    task automatic make_frame(output logic [7:0] f [18], input logic [5:0] bad_mask,
                              input int fill);
        logic [7:0] d0;
        logic [7:0] d1;
        logic [7:0] c;
        for (int g = 0; g < 6; g++) begin
            case (fill)
                1: begin
                    d0 = 8'h00;
                    d1 = 8'h00;
                end
                2: begin
                    d0 = 8'hFF;
                    d1 = 8'hFF;
                end
                default: begin
                    d0 = 8'($urandom_range(0, 255));
                    d1 = 8'($urandom_range(0, 255));
                end
            endcase
            c = crc8_next(crc8_next(CRC_INIT, d0), d1);
            if (bad_mask[g]) c = c ^ 8'($urandom_range(1, 255));
            f[3*g] = d0;
            f[3*g+1] = d1;
            f[3*g+2] = c;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (err_count < MAX_REPORTS) begin
            $display("mismatch %s: got %h, want %h (cycle %0d)", what, got, want, cycle_count);
        end
        err_count++;
    endtask

    // result side: random stall, the long hold-off, and the checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                readings_seen++;
                if (!o_frame_ok) failed_seen++;
                if (pending_readings.size() == 0) begin
                    report_mismatch("reading with nothing pending", o_co2_bits, '0);
                end else begin
                    t_result want;
                    want = pending_readings.pop_front();
                    if (o_co2_bits !== want.co2)
                        report_mismatch("co2_bits", o_co2_bits, want.co2);
                    if (o_temperature_bits !== want.temperature)
                        report_mismatch("temperature_bits", o_temperature_bits,
                                        want.temperature);
                    if (o_humidity_bits !== want.humidity)
                        report_mismatch("humidity_bits", o_humidity_bits, want.humidity);
                    if (o_frame_ok !== want.ok)
                        report_mismatch("frame_ok", 32'(o_frame_ok), 32'(want.ok));
                end
            end
            if (hold_left > 0) begin
                // long hold-off, counted here so the sender keeps going
                hold_left <= hold_left - 1;
                i_out_stall <= 1'b1;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_left <= HOLD_CYCLES;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !quiet && ($urandom_range(0, 99) < 19);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d readings pending", cycle_count,
                     pending_readings.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // directed rows: a clean frame right after reset without a frame start, using the
    // well-known 0xbeef -> 0x92 check pair, then idle bytes that must be ignored, then
    // two restarts, the second of which abandons the frame in progress
    localparam t_result BEEF_READING = {32'hBEEFBEEF, 32'hBEEFBEEF, 32'hBEEFBEEF, 1'b1};
    t_dir_row dir_rows [NUM_DIRECTED] = '{
        '{8'hBE, 1'b0, 1'b0, '0}, '{8'hEF, 1'b0, 1'b0, '0}, '{8'h92, 1'b0, 1'b0, '0},
        '{8'hBE, 1'b0, 1'b0, '0}, '{8'hEF, 1'b0, 1'b0, '0}, '{8'h92, 1'b0, 1'b0, '0},
        '{8'hBE, 1'b0, 1'b0, '0}, '{8'hEF, 1'b0, 1'b0, '0}, '{8'h92, 1'b0, 1'b0, '0},
        '{8'hBE, 1'b0, 1'b0, '0}, '{8'hEF, 1'b0, 1'b0, '0}, '{8'h92, 1'b0, 1'b0, '0},
        '{8'hBE, 1'b0, 1'b0, '0}, '{8'hEF, 1'b0, 1'b0, '0}, '{8'h92, 1'b0, 1'b0, '0},
        '{8'hBE, 1'b0, 1'b0, '0}, '{8'hEF, 1'b0, 1'b0, '0}, '{8'h92, 1'b0, 1'b1, BEEF_READING},
        // idle after a complete frame: no frame start, no result
        '{8'h00, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
        // restart, then restart again mid-group
        '{8'hFF, 1'b1, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b1, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0}
    };

    initial begin
        logic [7:0] frame [18];
        int         pick;
        int         fill;
        int         n;
        logic [5:0] mask;
        logic       drain_done;
        logic       hold_fired;

        err_count = 0;
        bytes_used = 0;
        readings_seen = 0;
        failed_seen = 0;
        cycle_count = 0;
        hold_left = 0;
        hold_req = 1'b0;
        quiet = 1'b0;
        drain_done = 1'b0;
        hold_fired = 1'b0;

        // model starts from the reset state
        frame_pos = '0;
        group_crc = CRC_INIT;
        frame_bad = 1'b0;
        for (int i = 0; i < NUM_WORDS; i++) begin
            words_in_progress[i] = '0;
            words_kept[i] = '0;
        end

        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_rx_byte <= '0;
        i_frame_start <= 1'b0;
        i_out_stall <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part
        for (int r = 0; r < NUM_DIRECTED; r++) begin
            send_byte(dir_rows[r].rx, dir_rows[r].start, dir_rows[r].typed, dir_rows[r].want);
        end

        // random part: mostly well-formed frames with random content
        while (bytes_used < BYTE_TARGET) begin
            // sender pause: let everything owed come out first
            if (!drain_done && bytes_used >= 500) begin
                drain_done = 1'b1;
                i_in_valid <= 1'b0;
                @(posedge i_clk);
                while (pending_readings.size() != 0) @(posedge i_clk);
            end
            // long receiver hold-off while bytes keep coming
            if (!hold_fired && bytes_used >= 800) begin
                hold_fired = 1'b1;
                hold_req = 1'b1;
            end
            // stretch with no idling on either side
            quiet = (bytes_used >= 1100 && bytes_used < 1450);

            pick = $urandom_range(0, 99);
            fill = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0;
            mask = '0;
            if (pick >= 60 && pick < 75) mask = 6'($urandom_range(1, 63));
            make_frame(frame, mask, fill);

            if (pick < 75) begin
                // full frame, good or with spoiled crc groups
                for (int i = 0; i < 18; i++) send_byte(frame[i], i == 0, 1'b0, '0);
            end else if (pick < 85) begin
                // frame cut short; the next frame start abandons it
                n = $urandom_range(1, 17);
                for (int i = 0; i < n; i++) send_byte(frame[i], i == 0, 1'b0, '0);
            end else if (pick < 93) begin
                // noise with occasional stray frame starts
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++) begin
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0, 1'b0, '0);
                end
            end else begin
                // frame without its start marker
                for (int i = 0; i < 18; i++) send_byte(frame[i], 1'b0, 1'b0, '0);
            end
        end
        quiet = 1'b0;
        i_in_valid <= 1'b0;

        // drain, then keep watching the outputs to catch any extra result
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("covered %0d frame bytes, %0d readings checked (%0d with a crc failure),",
                 bytes_used, readings_seen, failed_seen);
        $display("with restarts, idle bytes, random stalls and a %0d-cycle output hold-off",
                 HOLD_CYCLES);
        if (err_count == 0 && pending_readings.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
